// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file skl_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, muted while reset is high.
`define SKL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge.
`define SKL_NEVER(label, clk, rst, cond, msg) \
   `SKL_ASSERT(label, clk, rst, !(cond), msg)

`endif

// ===== src/skl_pkg.sv =====
// Shared constants and types for the sorted key list.
// Depends on nothing; used by sorted_key_list and skl_checker.
package skl_pkg;

   localparam int CAPACITY = 16;
   localparam int KEY_W    = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_LIST   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_INSERTED = 3'd0,
      STS_DELETED  = 3'd1,
      STS_NOTFOUND = 3'd2,
      STS_EMPTY    = 3'd3,
      STS_FULL     = 3'd4,
      STS_LISTED   = 3'd5
   } status_type;

endpackage

// ===== src/sorted_key_list.sv =====
// Sorted key list: keeps up to CAPACITY signed keys in ascending order in one
// single-port-read key memory. Depends on skl_pkg.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+--------------------------
//   request | req_action, req_key                     | start && !busy
//   result  | rsp_status, rsp_value, rsp_last         | rsp_strobe, one cycle
//
// One memory read per entry visited, one entry per cycle. An empty list, or for
// insert a full one, is answered from idle without a scan. A listing streams one
// key per cycle. Action code 3 gives no result. Results are registered and show
// in the cycle after their decision.
// Reset clears count, sequencer and strobe; the key memory is not cleared.
// The result side cannot stall; busy is the only back-pressure on requests.
module sorted_key_list (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic        [skl_pkg::ACTION_W-1:0] req_action,
   input  logic signed [skl_pkg::KEY_W-1:0]    req_key,
   output logic                                rsp_strobe,
   output logic        [skl_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [skl_pkg::KEY_W-1:0]    rsp_value,
   output logic                                rsp_last
);
   import skl_pkg::*;

   // Sequencer, one-hot.
   typedef enum logic [4:0] {
      SQ_IDLE = 5'b00001,
      SQ_INS  = 5'b00010,   // top-down scan, shifting entries up by one
      SQ_FILL = 5'b00100,   // new key goes to the front
      SQ_DEL  = 5'b01000,   // bottom-up scan, closing the gap behind the hit
      SQ_LIST = 5'b10000    // stream entries out
   } seq_type;

   seq_type                   state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [KEY_W-1:0]   key_ff, key_in;
   logic                      found_ff, found_in;
   logic [IDX_W-1:0]          rd_idx_ff, rd_idx_in;    // entry held in rd_data_ff

   logic                      rsp_strobe_ff, rsp_strobe_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [KEY_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Key memory: one write and one read port, registered read data.
   logic signed [KEY_W-1:0]   mem [CAPACITY];
   logic signed [KEY_W-1:0]   rd_data_ff;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic signed [KEY_W-1:0]   wr_data;

   logic [CNT_W-1:0]          cnt_dec;
   logic [IDX_W-1:0]          last_idx;
   logic                      at_end;
   logic                      hit;

   assign cnt_dec  = count_ff - CNT_W'(1);
   assign last_idx = cnt_dec[IDX_W-1:0];
   assign at_end   = (rd_idx_ff == last_idx);
   assign hit      = !found_ff && (rd_data_ff == key_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      found_in      = found_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STS_INSERTED;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = key_ff;

      case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               key_in   = req_key;
               found_in = 1'b0;
               case (req_action)
                  ACT_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_FULL;
                     end else if (count_ff == '0) begin
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data       = req_key;
                        count_in      = CNT_W'(1);
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_INSERTED;
                     end else begin
                        // scan from the top entry downward
                        rd_en     = 1'b1;
                        rd_addr   = last_idx;
                        rd_idx_in = last_idx;
                        state_in  = SQ_INS;
                     end
                  end
                  ACT_DELETE, ACT_LIST: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = '0;
                        rd_idx_in = '0;
                        state_in  = (req_action == ACT_LIST) ? SQ_LIST : SQ_DEL;
                     end
                  end
                  default: begin
                     // unused code: no state change, no result
                  end
               endcase
            end
         end

         SQ_INS: begin
            // Write lands two entries above the next read: no overlap.
            wr_en   = 1'b1;
            wr_addr = rd_idx_ff + IDX_W'(1);
            if (rd_data_ff >= key_ff) begin
               wr_data = rd_data_ff;
               if (rd_idx_ff == '0) begin
                  state_in = SQ_FILL;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = rd_idx_ff - IDX_W'(1);
                  rd_idx_in = rd_idx_ff - IDX_W'(1);
               end
            end else begin
               wr_data       = key_ff;
               count_in      = count_ff + CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = STS_INSERTED;
               state_in      = SQ_IDLE;
            end
         end

         SQ_FILL: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data       = key_ff;
            count_in      = count_ff + CNT_W'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = STS_INSERTED;
            state_in      = SQ_IDLE;
         end

         SQ_DEL: begin
            // Past the hit, each entry moves down one slot, behind the read.
            found_in = found_ff || hit;
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - IDX_W'(1);
               wr_data = rd_data_ff;
            end
            if (at_end) begin
               rsp_strobe_in = 1'b1;
               state_in      = SQ_IDLE;
               if (found_ff || hit) begin
                  rsp_status_in = STS_DELETED;
                  count_in      = cnt_dec;
               end else begin
                  rsp_status_in = STS_NOTFOUND;
               end
            end else begin
               rd_en     = 1'b1;
               rd_addr   = rd_idx_ff + IDX_W'(1);
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end

         SQ_LIST: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = STS_LISTED;
            rsp_value_in  = rd_data_ff;
            rsp_last_in   = at_end;
            if (at_end) begin
               state_in = SQ_IDLE;
            end else begin
               rd_en     = 1'b1;
               rd_addr   = rd_idx_ff + IDX_W'(1);
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end

         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SQ_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      found_ff      <= found_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy       = (state_ff != SQ_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== src/skl_checker.sv =====
// Port-level checks for sorted_key_list, attached by bind.
// Depends on skl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module skl_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic        [skl_pkg::ACTION_W-1:0] req_action,
   input logic signed [skl_pkg::KEY_W-1:0]    req_key,
   input logic                                rsp_strobe,
   input logic        [skl_pkg::STATUS_W-1:0] rsp_status,
   input logic signed [skl_pkg::KEY_W-1:0]    rsp_value,
   input logic                                rsp_last
);
   import skl_pkg::*;

   logic accept;
   logic listed;

   assign accept = start && !busy;
   assign listed = rsp_strobe && (rsp_status == STS_LISTED);

   // a listing streams without gaps up to its last beat
   `SKL_ASSERT(a_list_gapless, clock, reset, rsp_strobe && !rsp_last |=> rsp_strobe, "listing gap")
   // only listed beats may be non-final
   `SKL_NEVER(a_single_final, clock, reset, rsp_strobe && !listed && !rsp_last, "status not last")
   // value is zero unless a key is listed
   `SKL_NEVER(a_value_zero, clock, reset, rsp_strobe && !listed && (rsp_value != '0), "value set")
   // the unused action code yields no beat
   `SKL_ASSERT(a_unused_silent, clock, reset,
      accept && (req_action == ACT_NONE) |=> !rsp_strobe, "beat on unused action")

endmodule

bind sorted_key_list skl_checker u_skl_checker (.*);

// ===== sim/key_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for sorted_key_list: watches the request and result ports and predicts each result.
// Compares every result field by field. Depends on skl_pkg.
module key_list_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic        [skl_pkg::ACTION_W-1:0] req_action,
   input  logic signed [skl_pkg::KEY_W-1:0]    req_key,
   input  logic                                rsp_strobe,
   input  logic        [skl_pkg::STATUS_W-1:0] rsp_status,
   input  logic signed [skl_pkg::KEY_W-1:0]    rsp_value,
   input  logic                                rsp_last,
   output int                                  fail_count,
   output int                                  pending
);
   import skl_pkg::*;

   typedef struct {
      status_type              status;
      logic signed [KEY_W-1:0] value;
      logic                    last;
   } reply_type;

   reply_type               due_replies[$];
   logic signed [KEY_W-1:0] stored_keys[$];

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void push_reply(input status_type st, input logic signed [KEY_W-1:0] val,
                                      input logic lst);
      reply_type r;
      r.status = st;
      r.value  = val;
      r.last   = lst;
      due_replies.push_back(r);
   endfunction

   // Applies one accepted beat to the shadow list and queues its results.
   function automatic void apply_request(input action_type act,
                                         input logic signed [KEY_W-1:0] key);
      int pos;
      case (act)
         ACT_INSERT: begin
            if (stored_keys.size() >= CAPACITY) begin
               push_reply(STS_FULL, '0, 1'b1);
            end else begin
               pos = stored_keys.size();
               for (int i = 0; i < stored_keys.size(); i++) begin
                  if (stored_keys[i] >= key) begin
                     pos = i;
                     break;
                  end
               end
               stored_keys.insert(pos, key);
               push_reply(STS_INSERTED, '0, 1'b1);
            end
         end
         ACT_DELETE: begin
            if (stored_keys.size() == 0) begin
               push_reply(STS_EMPTY, '0, 1'b1);
            end else begin
               pos = -1;
               for (int i = 0; i < stored_keys.size(); i++) begin
                  if (stored_keys[i] == key) begin
                     pos = i;
                     break;
                  end
               end
               if (pos < 0) begin
                  push_reply(STS_NOTFOUND, '0, 1'b1);
               end else begin
                  stored_keys.delete(pos);
                  push_reply(STS_DELETED, '0, 1'b1);
               end
            end
         end
         ACT_LIST: begin
            if (stored_keys.size() == 0) begin
               push_reply(STS_EMPTY, '0, 1'b1);
            end else begin
               foreach (stored_keys[i]) begin
                  push_reply(STS_LISTED, stored_keys[i], i == stored_keys.size() - 1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic check_reply();
      reply_type want;
      if (due_replies.size() == 0) begin
         report_mismatch($sformatf("unexpected result status %0d value %0d",
                                   rsp_status, rsp_value));
      end else begin
         want = due_replies.pop_front();
         if (rsp_status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
         end
         if (rsp_value !== want.value) begin
            report_mismatch($sformatf("value %0d, expected %0d", rsp_value, want.value));
         end
         if (rsp_last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
         end
      end
   endtask

   // Results are checked before the beat accepted at the same edge is applied.
   always @(posedge clock) begin
      if (reset) begin
         due_replies.delete();
         stored_keys.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            check_reply();
         end
         if (start && !busy) begin
            apply_request(action_type'(req_action), req_key);
         end
      end
      pending = due_replies.size();
   end

endmodule

// ===== sim/tb_sorted_key_list.sv =====
`timescale 1ns / 1ps
// Top of the sorted_key_list testbench: clock, reset, stimulus and verdict.
// Depends on skl_pkg, sorted_key_list and key_list_checker.
module tb_sorted_key_list;
   import skl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [ACTION_W-1:0]     req_action = ACT_INSERT;
   logic signed [KEY_W-1:0] req_key = '0;
   logic                    rsp_strobe;
   logic [STATUS_W-1:0]     rsp_status;
   logic signed [KEY_W-1:0] rsp_value;
   logic                    rsp_last;

   int fail_count;
   int pending;
   int cycle_count = 0;

   // Stimulus-side memory of recently inserted keys, so deletes hit often.
   logic signed [KEY_W-1:0] recent_keys[16];
   int                      recent_wr = 0;
   // While set, beats go back to back with no idle cycles.
   bit                      no_idle = 1'b0;

   always #1 clock = ~clock;

   sorted_key_list dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_key    (req_key),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_last)
   );

   key_list_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_key    (req_key),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_last),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Watchdog: a hung handshake or a missing result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Drives one beat. Entered and left at a falling edge; start stays high
   // on exit so a back-to-back beat needs no extra assignment.
   task automatic send_beat(input action_type act, input logic signed [KEY_W-1:0] key);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start      <= 1'b1;
      req_action <= act;
      req_key    <= key;
      do @(posedge clock); while (busy);
      if (act == ACT_INSERT) begin
         recent_keys[recent_wr % 16] = key;
         recent_wr++;
      end
      @(negedge clock);
   endtask

   // Holds off the sender until every predicted result has arrived.
   task automatic drain();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // Keys cluster on extremes, a small band around zero and earlier inserts,
   // so duplicates and delete hits are common; the rest are fully random.
   function automatic logic signed [KEY_W-1:0] pick_key(input bit for_delete);
      int r;
      r = $urandom_range(0, 9);
      if (for_delete && r < 6 && recent_wr > 0) begin
         return recent_keys[$urandom_range(0, (recent_wr < 16 ? recent_wr : 16) - 1)];
      end
      case (r)
         0:       return {1'b1, {(KEY_W-1){1'b0}}};
         1:       return {1'b0, {(KEY_W-1){1'b1}}};
         2, 3, 4: return $signed($urandom_range(0, 6)) - 3;
         5, 6:    return (recent_wr > 0) ? recent_keys[$urandom_range(0, 15) % 16] : '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic action_type pick_action(input int ins_pct, input int del_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < ins_pct) return ACT_INSERT;
      if (r < ins_pct + del_pct) return ACT_DELETE;
      if (r < 97) return ACT_LIST;
      return ACT_NONE;
   endfunction

   initial begin
      action_type act;
      int         ins_pct;
      int         del_pct;
      int         n_beats;

      foreach (recent_keys[i]) recent_keys[i] = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty cases, key extremes, duplicates, miss, unused code.
      send_beat(ACT_LIST, '0);
      send_beat(ACT_DELETE, 32'sd7);
      send_beat(ACT_INSERT, {1'b0, {(KEY_W-1){1'b1}}});
      send_beat(ACT_INSERT, {1'b1, {(KEY_W-1){1'b0}}});
      send_beat(ACT_INSERT, '0);
      send_beat(ACT_INSERT, -32'sd1);
      send_beat(ACT_INSERT, '0);
      send_beat(ACT_INSERT, {1'b0, {(KEY_W-1){1'b1}}});
      send_beat(ACT_LIST, '0);
      send_beat(ACT_DELETE, 32'sd5);
      send_beat(ACT_DELETE, '0);
      send_beat(ACT_DELETE, {1'b1, {(KEY_W-1){1'b0}}});
      send_beat(ACT_NONE, '1);
      send_beat(ACT_LIST, '1);
      drain();

      // Random phases: fill to full, churn, empty out, churn, refill.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0, 4: begin ins_pct = 88; del_pct = 2;  n_beats = 24; end
            2:    begin ins_pct = 5;  del_pct = 80; n_beats = 24; end
            default: begin ins_pct = 45; del_pct = 38; n_beats = 16; end
         endcase
         no_idle = (phase == 0) || (phase == 3);
         for (int i = 0; i < n_beats; i++) begin
            act = pick_action(ins_pct, del_pct);
            send_beat(act, pick_key(act == ACT_DELETE));
         end
         send_beat(ACT_LIST, $urandom);
         if (phase % 2 == 0) begin
            drain();
         end
      end

      // Wind down: no more beats, wait for the tail of results, then settle.
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
